[rtl/core/tjp_pkg.sv]
// Shared types and constants for the tiered job picker.
`timescale 1ns / 1ps
`default_nettype none
package tjp_pkg;

	localparam int DefQueueDepth = 16;
	localparam int DefMaxParents = 4;
	localparam int DefNumWorkers = 8;
	localparam int ParentSlots   = 4;

	localparam logic       FUNC_PUSH   = 1'b0;
	localparam logic       FUNC_PICK   = 1'b1;
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	typedef struct packed {
		logic        func;
		logic [15:0] job_key;
		logic [9:0]  batch;
		logic [7:0]  depth;
		logic [7:0]  child_count;
		logic [2:0]  parent_count;
		logic [15:0] parent_key_a;
		logic [15:0] parent_key_b;
		logic [15:0] parent_key_c;
		logic [15:0] parent_key_d;
		logic [2:0]  worker_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] picked_key;
		logic [2:0]  picked_worker;
		logic [4:0]  queue_level;
	} rsp_t;

	typedef struct packed {
		logic [15:0]                  key;
		logic [9:0]                   batch;
		logic [7:0]                   depth;
		logic [7:0]                   children;
		logic [2:0]                   pcnt;
		logic [ParentSlots-1:0][15:0] parents;
	} entry_t;

	// Running value handed from cell to cell during a scan.
	typedef struct packed {
		logic        have;
		logic [9:0]  val;
		logic [15:0] key;
	} run_t;

	typedef enum logic [2:0] {
		M_BATCH, M_DEPTH, M_LOC, M_CHILD, M_FIRST, M_FIFO
	} scan_mode_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_PUSH, OP_SCAN, OP_APPLY, OP_REMOVE
	} cell_op_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		cell_op_t    op;
		scan_mode_t  mode;
		entry_t      entry;
		run_t        best;
		logic        has_last;
		logic [15:0] last_key;
	} ctl_t;

endpackage
`default_nettype wire

[rtl/core/tjp_cell.sv]
// One queue slot of the job chain with its share of the selection scans.
`timescale 1ns / 1ps
`default_nettype none
module tjp_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tjp_pkg::ctl_t   ctl,
	input  wire logic            prev_valid,
	input  wire tjp_pkg::run_t   prev_run,
	input  wire tjp_pkg::entry_t next_entry,
	input  wire logic            next_valid,
	output tjp_pkg::entry_t      entry,
	output logic                 valid,
	output tjp_pkg::run_t        run
);
	import tjp_pkg::*;

	entry_t entry_q;
	logic   valid_q;
	logic   cand_q;
	run_t   run_q;
	run_t   run_next;
	logic   loc;

	assign entry = entry_q;
	assign valid = valid_q;
	assign run   = run_q;

	// Locality: no parents, or one of the stored parents is the worker's last job.
	always_comb begin
		loc = (entry_q.pcnt == 3'd0);
		for (int p = 0; p < ParentSlots; p++) begin
			if (ctl.has_last && (3'(p) < entry_q.pcnt) && (entry_q.parents[p] == ctl.last_key))
				loc = 1'b1;
		end
	end

	// Combine this slot into the running value from the left neighbor.
	always_comb begin
		run_next = prev_run;
		case (ctl.mode)
			M_BATCH: begin
				if (valid_q && (!prev_run.have || entry_q.batch < prev_run.val))
					run_next = '{have: 1'b1, val: entry_q.batch, key: entry_q.key};
			end
			M_DEPTH: begin
				if (cand_q && (!prev_run.have || {2'b0, entry_q.depth} < prev_run.val))
					run_next = '{have: 1'b1, val: {2'b0, entry_q.depth}, key: entry_q.key};
			end
			M_CHILD: begin
				if (cand_q && (!prev_run.have || {2'b0, entry_q.children} > prev_run.val))
					run_next = '{have: 1'b1, val: {2'b0, entry_q.children}, key: entry_q.key};
			end
			M_LOC: begin
				run_next.have = prev_run.have | (cand_q & loc);
			end
			M_FIRST: begin
				if (cand_q && !prev_run.have)
					run_next = '{have: 1'b1, val: '0, key: entry_q.key};
			end
			default: begin
				run_next = prev_run;
			end
		endcase
	end

	// Control state of the slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= 1'b0;
		end else begin
			case (ctl.op)
				OP_PUSH: begin
					if (!valid_q && prev_valid)
						valid_q <= 1'b1;
				end
				OP_APPLY: begin
					case (ctl.mode)
						M_BATCH: cand_q <= valid_q && (entry_q.batch == ctl.best.val);
						M_DEPTH: cand_q <= cand_q && ({2'b0, entry_q.depth} == ctl.best.val);
						M_LOC:   cand_q <= ctl.best.have ? (cand_q && loc) : cand_q;
						M_CHILD: cand_q <= cand_q && ({2'b0, entry_q.children} == ctl.best.val);
						M_FIFO:  cand_q <= valid_q;
						default: cand_q <= cand_q;
					endcase
				end
				OP_REMOVE: begin
					// Slots at or behind the picked one move up by one place.
					if (run_q.have)
						valid_q <= next_valid;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	// Payload and running value.
	always_ff @(posedge clk) begin
		if (ctl.op == OP_PUSH && !valid_q && prev_valid)
			entry_q <= ctl.entry;
		if (ctl.op == OP_REMOVE && run_q.have)
			entry_q <= next_entry;
		if (ctl.op == OP_SCAN)
			run_q <= run_next;
	end

endmodule
`default_nettype wire

[rtl/core/tiered_job_picker_unit.sv]
// Top level of the tiered job picker: sequencer, worker history and the chain of slots.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to QUEUE_DEPTH jobs in a chain of slots, one job per slot, in arrival order.
// A push stores the job in the first free slot as the request is taken. A pick runs scans
// along the chain; each scan moves a running value one slot per cycle. In first-in mode
// a pick runs one update step and one scan; in tiered mode it runs five scans (batch,
// depth, locality, child count, first candidate) with an update step between each two.
// A full push and an empty pick go straight to the result. A new request is taken once the
// previous one has left the sequencer, which waits only while an unread result is stalled.
module tiered_job_picker_unit #(
	parameter int QUEUE_DEPTH = tjp_pkg::DefQueueDepth,
	parameter int MAX_PARENTS = tjp_pkg::DefMaxParents,
	parameter int NUM_WORKERS = tjp_pkg::DefNumWorkers
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire logic    cfg_wdata,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire tjp_pkg::req_t req,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	output tjp_pkg::rsp_t rsp
);
	import tjp_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(QUEUE_DEPTH);
	localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_REMOVE, S_FINISH} state_t;

	state_t      state_q;
	scan_mode_t  mode_q;
	logic [NW-1:0] cnt_q;
	logic [CW-1:0] level_q;
	logic        policy_q;
	logic [2:0]  worker_q;
	logic        has_last_q;
	logic [15:0] last_sel_q;
	logic [1:0]  status_q;
	logic [15:0] key_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic [15:0]      last_key_q [NUM_WORKERS];
	logic [NUM_WORKERS-1:0] last_vld_q;

	ctl_t   ctl;
	entry_t push_entry;
	logic   accept;
	logic   full;
	logic   in_range;
	logic   rsp_load;
	logic [WW-1:0] widx;
	logic [WW-1:0] widx_q;
	logic [2:0]    pcnt_sat;

	entry_t ent   [QUEUE_DEPTH];
	logic   vld   [QUEUE_DEPTH];
	run_t   runs  [QUEUE_DEPTH];

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign full      = (level_q == CW'(QUEUE_DEPTH));
	assign in_range  = (32'(req.worker_id) < NUM_WORKERS);
	assign widx      = WW'(req.worker_id);
	assign widx_q    = WW'(worker_q);
	assign rsp_load  = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);

	// Build the stored form of a pushed job, with the parent count saturated.
	always_comb begin
		pcnt_sat = (32'(req.parent_count) > MAX_PARENTS) ? 3'(MAX_PARENTS) : req.parent_count;
		push_entry.key      = req.job_key;
		push_entry.batch    = req.batch;
		push_entry.depth    = req.depth;
		push_entry.children = req.child_count;
		push_entry.pcnt     = pcnt_sat;
		push_entry.parents[0] = (3'd0 < pcnt_sat) ? req.parent_key_a : 16'd0;
		push_entry.parents[1] = (3'd1 < pcnt_sat) ? req.parent_key_b : 16'd0;
		push_entry.parents[2] = (3'd2 < pcnt_sat) ? req.parent_key_c : 16'd0;
		push_entry.parents[3] = (3'd3 < pcnt_sat) ? req.parent_key_d : 16'd0;
	end

	// Broadcast control to the chain.
	always_comb begin
		ctl.op       = OP_NONE;
		ctl.mode     = mode_q;
		ctl.entry    = push_entry;
		ctl.best     = runs[QUEUE_DEPTH-1];
		ctl.has_last = has_last_q;
		ctl.last_key = last_sel_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.func == FUNC_PUSH && !full)
					ctl.op = OP_PUSH;
			end
			S_SCAN:   ctl.op = OP_SCAN;
			S_APPLY:  ctl.op = OP_APPLY;
			S_REMOVE: ctl.op = OP_REMOVE;
			default:  ctl.op = OP_NONE;
		endcase
	end

	// Chain of slots; each takes its neighbors' values.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   pv;
		run_t   pr;
		entry_t ne;
		logic   nv;
		if (i == 0) begin : g_head
			assign pv = 1'b1;
			assign pr = '0;
		end else begin : g_body
			assign pv = vld[i-1];
			assign pr = runs[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign ne = '0;
			assign nv = 1'b0;
		end else begin : g_mid
			assign ne = ent[i+1];
			assign nv = vld[i+1];
		end
		tjp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (pv),
			.prev_run   (pr),
			.next_entry (ne),
			.next_valid (nv),
			.entry      (ent[i]),
			.valid      (vld[i]),
			.run        (runs[i])
		);
	end

	// Sequencer, counters and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_FIFO;
			cnt_q       <= '0;
			level_q     <= '0;
			policy_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			last_vld_q  <= '0;
			has_last_q  <= 1'b0;
		end else begin
			if (cfg_we)
				policy_q <= cfg_wdata;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (req.func == FUNC_PICK && level_q != '0) begin
							has_last_q <= in_range && last_vld_q[widx];
							mode_q     <= policy_q ? M_BATCH : M_FIFO;
							state_q    <= policy_q ? S_SCAN : S_APPLY;
						end else begin
							state_q <= S_FINISH;
							if (req.func == FUNC_PUSH && !full)
								level_q <= level_q + 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q == NW'(QUEUE_DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= (mode_q == M_FIRST) ? S_REMOVE : S_APPLY;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_APPLY: begin
					state_q <= S_SCAN;
					case (mode_q)
						M_BATCH: mode_q <= M_DEPTH;
						M_DEPTH: mode_q <= M_LOC;
						M_LOC:   mode_q <= M_CHILD;
						default: mode_q <= M_FIRST;
					endcase
				end
				S_REMOVE: begin
					level_q <= level_q - 1'b1;
					if (32'(worker_q) < NUM_WORKERS)
						last_vld_q[widx_q] <= 1'b1;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (rsp_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload and worker history.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			worker_q   <= (req.func == FUNC_PICK && level_q != '0) ? req.worker_id : 3'd0;
			last_sel_q <= last_key_q[widx];
			key_q      <= '0;
			if (req.func == FUNC_PUSH)
				status_q <= full ? ST_FULL : ST_DONE;
			else
				status_q <= (level_q == '0) ? ST_EMPTY : ST_DONE;
		end
		if (state_q == S_REMOVE) begin
			key_q <= runs[QUEUE_DEPTH-1].key;
			if (32'(worker_q) < NUM_WORKERS)
				last_key_q[widx_q] <= runs[QUEUE_DEPTH-1].key;
		end
		if (rsp_load) begin
			rsp_q.status        <= status_q;
			rsp_q.picked_key    <= key_q;
			rsp_q.picked_worker <= worker_q;
			rsp_q.queue_level   <= 5'(level_q);
		end
	end

endmodule
`default_nettype wire
